// ===== rtl/fla_pkg.sv =====
package fla_pkg;

  localparam int WORD_W = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int LANE_W = 8;
  localparam int LANES = WORD_W / LANE_W;
  localparam int DEF_MAX_ORBITALS = 64;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_ANNIHILATE = 1'b1;

  localparam logic SPIN_ALPHA = 1'b0;
  localparam logic SPIN_BETA = 1'b1;

  localparam logic ORDER_ALPHA_FIRST = 1'b0;
  localparam logic ORDER_INTERLEAVED = 1'b1;

  localparam logic REG_SPIN_ORDER = 1'b0;
  localparam logic REG_ORBITAL_COUNT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] alpha;
    logic [WORD_W-1:0] beta;
    logic [WORD_W-1:0] tsel;
    logic [WORD_W-1:0] asel;
    logic [IDX_W-1:0]  idx;
    logic              spin;
    logic              apply;
  } fla_mask_t;

  typedef struct packed {
    logic [WORD_W-1:0] alpha;
    logic [WORD_W-1:0] beta;
    logic [LANES-1:0]  tpar;
    logic [LANES-1:0]  apar;
    logic [IDX_W-1:0]  idx;
    logic              spin;
    logic              apply;
  } fla_par_t;

  typedef struct packed {
    logic              applied;
    logic              negative;
    logic [WORD_W-1:0] alpha;
    logic [WORD_W-1:0] beta;
  } fla_res_t;

endpackage

// ===== rtl/fla_mask.sv =====
module fla_mask import fla_pkg::*; #(
  parameter int MAX_ORBITALS = DEF_MAX_ORBITALS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              spin_order,
  input  logic [CNT_W-1:0]  orbital_count,
  input  logic              kind,
  input  logic              spin_select,
  input  logic [IDX_W-1:0]  orbital_index,
  input  logic [WORD_W-1:0] alpha_bits,
  input  logic [WORD_W-1:0] beta_bits,
  output logic              out_valid,
  output fla_mask_t         out_word
);

  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ORBITALS);

  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] used;
  logic [WORD_W-1:0] below;
  logic [WORD_W-1:0] upto;
  logic [WORD_W-1:0] alpha_m;
  logic [WORD_W-1:0] beta_m;
  logic [WORD_W-1:0] target;
  logic              occ;
  logic              in_range;
  fla_mask_t         word_next;

  always_comb begin
    cnt = (orbital_count > MaxCount) ? MaxCount : orbital_count;
    for (int i = 0; i < WORD_W; i++) begin
      used[i]  = CNT_W'(i) < cnt;
      below[i] = IDX_W'(i) < orbital_index;
      upto[i]  = IDX_W'(i) <= orbital_index;
    end
    alpha_m  = alpha_bits & used;
    beta_m   = beta_bits & used;
    target   = (spin_select == SPIN_BETA) ? beta_m : alpha_m;
    occ      = target[orbital_index];
    in_range = {1'b0, orbital_index} < cnt;

    word_next.alpha = alpha_m;
    word_next.beta  = beta_m;
    word_next.tsel  = target & below;
    if (spin_select == SPIN_ALPHA) begin
      word_next.asel = '0;
    end else if (spin_order == ORDER_INTERLEAVED) begin
      word_next.asel = alpha_m & upto;
    end else begin
      word_next.asel = alpha_m;
    end
    word_next.idx   = orbital_index;
    word_next.spin  = spin_select;
    word_next.apply = in_range && ((kind == KIND_CREATE) ? !occ : occ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== rtl/fla_parity.sv =====
module fla_parity import fla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  fla_mask_t in_word,
  output logic      out_valid,
  output fla_par_t  out_word
);

  fla_par_t word_next;

  always_comb begin
    word_next.alpha = in_word.alpha;
    word_next.beta  = in_word.beta;
    for (int l = 0; l < LANES; l++) begin
      word_next.tpar[l] = ^in_word.tsel[l*LANE_W +: LANE_W];
      word_next.apar[l] = ^in_word.asel[l*LANE_W +: LANE_W];
    end
    word_next.idx   = in_word.idx;
    word_next.spin  = in_word.spin;
    word_next.apply = in_word.apply;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== rtl/fla_resolve.sv =====
module fla_resolve import fla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  fla_par_t in_word,
  output logic     out_valid,
  output fla_res_t out_word
);

  logic [WORD_W-1:0] flip;
  fla_res_t          word_next;

  always_comb begin
    flip = WORD_W'(1) << in_word.idx;
    word_next.applied  = in_word.apply;
    word_next.negative = in_word.apply & (^in_word.tpar ^ ^in_word.apar);
    word_next.alpha    = in_word.alpha;
    word_next.beta     = in_word.beta;
    if (in_word.apply) begin
      if (in_word.spin == SPIN_BETA) begin
        word_next.beta = in_word.beta ^ flip;
      end else begin
        word_next.alpha = in_word.alpha ^ flip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== rtl/fermion_ladder_operator.sv =====
// Fermionic ladder operator with Jordan-Wigner sign.
// Input channel: in_valid / in_stall carry one word per operation (kind,
// spin_select, orbital_index and both occupation strings).
// Output channel: out_valid / out_stall carry one result word per input word:
// valid_res, sign_negative and the two new strings, masked to orbital_count.
// Configuration: wr_en with wr_index 0 writes spin_order, index 1 writes
// orbital_count; write only while the pipe is empty.
// One word is taken every cycle while in_stall is low; the three register
// stages (masking, per-byte parity, final reduce and bit flip) all advance
// together.
// When out_stall holds a valid result, every stage freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipe, sets spin_order to alpha-first and orbital_count
// to 64.
module fermion_ladder_operator import fla_pkg::*; #(
  parameter int MAX_ORBITALS = DEF_MAX_ORBITALS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [CNT_W-1:0]  wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic              spin_select,
  input  logic [IDX_W-1:0]  orbital_index,
  input  logic [WORD_W-1:0] alpha_bits,
  input  logic [WORD_W-1:0] beta_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              valid_res,
  output logic              sign_negative,
  output logic [WORD_W-1:0] new_alpha_bits,
  output logic [WORD_W-1:0] new_beta_bits
);

  logic             spin_order;
  logic [CNT_W-1:0] orbital_count;
  logic             en;
  logic             v1;
  logic             v2;
  fla_mask_t        w1;
  fla_par_t         w2;
  fla_res_t         w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_order    <= ORDER_ALPHA_FIRST;
      orbital_count <= CNT_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SPIN_ORDER:    spin_order <= wr_data[0];
        REG_ORBITAL_COUNT: orbital_count <= wr_data;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fla_mask #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_mask (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .spin_order   (spin_order),
    .orbital_count(orbital_count),
    .kind         (kind),
    .spin_select  (spin_select),
    .orbital_index(orbital_index),
    .alpha_bits   (alpha_bits),
    .beta_bits    (beta_bits),
    .out_valid    (v1),
    .out_word     (w1)
  );

  fla_parity u_parity (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .in_word  (w1),
    .out_valid(v2),
    .out_word (w2)
  );

  fla_resolve u_resolve (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_word  (w2),
    .out_valid(out_valid),
    .out_word (w3)
  );

  assign valid_res      = w3.applied;
  assign sign_negative  = w3.negative;
  assign new_alpha_bits = w3.alpha;
  assign new_beta_bits  = w3.beta;

endmodule

// ===== tb/fla_checker.sv =====
module fla_checker import fla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [CNT_W-1:0]  wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              kind,
  input  logic              spin_select,
  input  logic [IDX_W-1:0]  orbital_index,
  input  logic [WORD_W-1:0] alpha_bits,
  input  logic [WORD_W-1:0] beta_bits,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              valid_res,
  input  logic              sign_negative,
  input  logic [WORD_W-1:0] new_alpha_bits,
  input  logic [WORD_W-1:0] new_beta_bits,
  output int                errors,
  output int                pending
);

  localparam int MAX_ORB = DEF_MAX_ORBITALS;

  logic             cur_order;
  logic [CNT_W-1:0] cur_count;
  fla_res_t         expected_q[$];

  function automatic logic [WORD_W-1:0] low_bits(int n);
    if (n >= WORD_W) return '1;
    return (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

  function automatic fla_res_t ladder_predict(logic op, logic spin, logic [IDX_W-1:0] idx,
                                              logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    int                n;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] hit;
    fla_res_t          r;
    n = (int'(cur_count) > MAX_ORB) ? MAX_ORB : int'(cur_count);
    r.applied = 1'b0;
    r.negative = 1'b0;
    r.alpha = a & low_bits(n);
    r.beta = b & low_bits(n);
    if (int'(idx) >= n) return r;
    target = (spin == SPIN_BETA) ? r.beta : r.alpha;
    hit = WORD_W'(1) << idx;
    // create on occupied or annihilate on empty: blocked
    if ((op == KIND_CREATE) == ((target & hit) != '0)) return r;
    r.negative = ^(target & low_bits(int'(idx)));
    if (spin == SPIN_BETA) begin
      if (cur_order == ORDER_ALPHA_FIRST) r.negative ^= ^r.alpha;
      else r.negative ^= ^(r.alpha & low_bits(int'(idx) + 1));
    end
    target ^= hit;
    if (spin == SPIN_BETA) r.beta = target;
    else r.alpha = target;
    r.applied = 1'b1;
    return r;
  endfunction

  task automatic check_field(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    fla_res_t want;
    if (rst) begin
      cur_order = ORDER_ALPHA_FIRST;
      cur_count = CNT_W'(DEF_MAX_ORBITALS);
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result word with nothing expected", $time);
        end else begin
          want = expected_q.pop_front();
          check_field("valid_res", WORD_W'(want.applied), WORD_W'(valid_res));
          check_field("sign_negative", WORD_W'(want.negative), WORD_W'(sign_negative));
          check_field("new_alpha_bits", want.alpha, new_alpha_bits);
          check_field("new_beta_bits", want.beta, new_beta_bits);
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          ladder_predict(kind, spin_select, orbital_index,
                                         alpha_bits, beta_bits));
      if (wr_en) begin
        if (wr_index == REG_SPIN_ORDER) cur_order = wr_data[0];
        else if (wr_index == REG_ORBITAL_COUNT) cur_count = wr_data;
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/fermion_ladder_operator_tb.sv =====
module fermion_ladder_operator_tb;
  import fla_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en = 1'b0;
  logic              wr_index = REG_SPIN_ORDER;
  logic [CNT_W-1:0]  wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              kind = KIND_CREATE;
  logic              spin_select = SPIN_ALPHA;
  logic [IDX_W-1:0]  orbital_index = '0;
  logic [WORD_W-1:0] alpha_bits = '0;
  logic [WORD_W-1:0] beta_bits = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              valid_res;
  logic              sign_negative;
  logic [WORD_W-1:0] new_alpha_bits;
  logic [WORD_W-1:0] new_beta_bits;

  int                mismatches;
  int                in_flight;
  logic [CNT_W-1:0]  tb_count = CNT_W'(DEF_MAX_ORBITALS);
  bit                burst = 1'b0;

  localparam logic [WORD_W-1:0] ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

  logic             phase_order[8] = '{ORDER_ALPHA_FIRST, ORDER_INTERLEAVED,
                                       ORDER_ALPHA_FIRST, ORDER_INTERLEAVED,
                                       ORDER_ALPHA_FIRST, ORDER_INTERLEAVED,
                                       ORDER_ALPHA_FIRST, ORDER_INTERLEAVED};
  logic [CNT_W-1:0] phase_count[8] = '{7'd64, 7'd64, 7'd1, 7'd2, 7'd0, 7'd100, 7'd33, 7'd127};

  fermion_ladder_operator dut (.*);

  fla_checker u_check (.*, .errors(mismatches), .pending(in_flight));

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] shaped_word();
    case ($urandom_range(0, 5))
      0: return rand_word() & rand_word() & rand_word();
      1: return rand_word() | rand_word();
      2: return '0;
      3: return '1;
      default: return rand_word();
    endcase
  endfunction

  task automatic send_op(logic op, logic spin, logic [IDX_W-1:0] idx,
                         logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    int gap;
    bit stalled;
    gap = burst ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    spin_select <= spin;
    orbital_index <= idx;
    alpha_bits <= a;
    beta_bits <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_config(logic order, logic [CNT_W-1:0] count);
    wr_en <= 1'b1;
    wr_index <= REG_SPIN_ORDER;
    wr_data <= CNT_W'(order);
    @(posedge clk);
    wr_index <= REG_ORBITAL_COUNT;
    wr_data <= count;
    @(posedge clk);
    wr_en <= 1'b0;
    tb_count = count;
  endtask

  task automatic send_random_op();
    int                n;
    logic              op;
    logic              spin;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] hit;
    n = (int'(tb_count) > DEF_MAX_ORBITALS) ? DEF_MAX_ORBITALS : int'(tb_count);
    op = 1'($urandom_range(0, 1));
    spin = 1'($urandom_range(0, 1));
    a = shaped_word();
    b = shaped_word();
    if (n == 0 || $urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, 63));
    else idx = IDX_W'($urandom_range(0, n - 1));
    // mostly make the target bit suit the operator
    if ($urandom_range(0, 4) != 0) begin
      hit = WORD_W'(1) << idx;
      if (spin == SPIN_BETA) b = (op == KIND_CREATE) ? (b & ~hit) : (b | hit);
      else a = (op == KIND_CREATE) ? (a & ~hit) : (a | hit);
    end
    send_op(op, spin, idx, a, b);
  endtask

  initial begin
    int free_len;
    int hold_len;
    forever begin
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      repeat (hold_len) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n_items;
    logic             order;
    logic [CNT_W-1:0] count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: alpha first, 64 orbitals
    burst = 1'b1;
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd0, '0, '0);
    send_op(KIND_ANNIHILATE, SPIN_ALPHA, 6'd63, ONES, ONES);
    send_op(KIND_CREATE, SPIN_BETA, 6'd63, ONES, ~TOP_BIT);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd0, 64'h1, 64'h1);
    send_op(KIND_CREATE, SPIN_BETA, 6'd31, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd5, ONES, '0);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd10, ONES, '0);
    send_op(KIND_ANNIHILATE, SPIN_ALPHA, 6'd32, 64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    load_config(ORDER_INTERLEAVED, 7'd64);
    send_op(KIND_CREATE, SPIN_BETA, 6'd40, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd63, ONES, ONES);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd0, 64'h1, 64'h1);
    drain();
    // index range and bits beyond the orbital count
    load_config(ORDER_INTERLEAVED, 7'd20);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd20, ONES, ONES);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd63, ONES, ONES);
    send_op(KIND_CREATE, SPIN_BETA, 6'd19, ONES, 64'hFFFF_FFFF_FFF7_FFFF);
    send_op(KIND_ANNIHILATE, SPIN_ALPHA, 6'd0, 64'hFFFF_0000_0000_0001, rand_word());
    drain();
    load_config(ORDER_ALPHA_FIRST, 7'd1);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd0, 64'hFFFF_FFFF_FFFF_FFFE, ONES);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd0, ONES, ONES);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd1, '0, '0);
    drain();
    // zero orbitals: nothing applies, strings come back empty
    load_config(ORDER_ALPHA_FIRST, 7'd0);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd0, ONES, ONES);
    send_op(KIND_ANNIHILATE, SPIN_BETA, 6'd0, ONES, ONES);
    drain();
    // counts above the maximum clamp to 64
    load_config(ORDER_INTERLEAVED, 7'd127);
    send_op(KIND_CREATE, SPIN_BETA, 6'd63, ONES, ~TOP_BIT);
    send_op(KIND_ANNIHILATE, SPIN_ALPHA, 6'd63, ONES, '0);
    drain();
    load_config(ORDER_ALPHA_FIRST, 7'd65);
    send_op(KIND_CREATE, SPIN_ALPHA, 6'd63, ~TOP_BIT, '0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p < 8) begin
        order = phase_order[p];
        count = phase_count[p];
      end else begin
        order = 1'($urandom_range(0, 1));
        count = CNT_W'($urandom_range(1, 64));
      end
      load_config(order, count);
      n_items = (count == 0) ? 20 : 90;
      for (int i = 0; i < n_items; i++) begin
        if (i % 25 == 0) burst = ($urandom_range(0, 2) == 0);
        send_random_op();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fla_pkg.sv
rtl/fla_mask.sv
rtl/fla_parity.sv
rtl/fla_resolve.sv
rtl/fermion_ladder_operator.sv
tb/fla_checker.sv
tb/fermion_ladder_operator_tb.sv
